// File: rtl/adc_ladder_button_debounce_top_macros.svh
// Assertion macros for the ladder button debounce block.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef ADC_LADDER_BUTTON_DEBOUNCE_TOP_MACROS_SVH
`define ADC_LADDER_BUTTON_DEBOUNCE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ALDB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ALDB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ALDB_ASSERT(lbl, prop, msg)
`define ALDB_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: rtl/aldb_pkg.sv
// Shared types and constants of the ladder button debounce block.
// No dependencies.
`default_nettype none
package aldb_pkg;
  localparam int SAMPLE_WIDTH_DEF = 10;
  localparam int REG_W            = 10;
  localparam int BTN_W            = 3;
  localparam int HELD_W           = 11;
  localparam int CFG_IDX_W        = 3;

  localparam logic [BTN_W-1:0] BTN_NONE  = 3'd0;
  localparam logic [BTN_W-1:0] BTN_UP    = 3'd1;
  localparam logic [BTN_W-1:0] BTN_RIGHT = 3'd2;
  localparam logic [BTN_W-1:0] BTN_DOWN  = 3'd3;
  localparam logic [BTN_W-1:0] BTN_LEFT  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_UP_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd4;

  localparam logic [REG_W-1:0] UP_LIMIT_RST    = 10'd155;
  localparam logic [REG_W-1:0] RIGHT_LIMIT_RST = 10'd310;
  localparam logic [REG_W-1:0] DOWN_LIMIT_RST  = 10'd465;
  localparam logic [REG_W-1:0] LEFT_LIMIT_RST  = 10'd992;
  localparam logic [REG_W-1:0] DEBOUNCE_RST    = 10'd80;

  typedef struct packed {
    logic [REG_W-1:0] up_limit;
    logic [REG_W-1:0] right_limit;
    logic [REG_W-1:0] down_limit;
    logic [REG_W-1:0] left_limit;
    logic [REG_W-1:0] debounce_time;
  } cfg_t;

  typedef struct packed {
    logic [BTN_W-1:0]  candidate_button;
    logic [BTN_W-1:0]  stable_button;
    logic [HELD_W-1:0] held_time;
  } state_t;

  typedef struct packed {
    state_t           state;
    logic             emit;
    logic [BTN_W-1:0] pressed_button;
  } step_t;
endpackage
`default_nettype wire

// File: rtl/aldb_if.sv
// Valid/ready channel interfaces for samples in and button presses out.
// Depends on aldb_pkg.
`default_nettype none
interface aldb_in_if #(
  parameter int SAMPLE_WIDTH = aldb_pkg::SAMPLE_WIDTH_DEF
);
  logic                     valid;
  logic                     ready;
  logic [SAMPLE_WIDTH-1:0]  adc_sample;
  logic [aldb_pkg::REG_W-1:0] elapsed_time;

  modport source (output valid, output adc_sample, output elapsed_time, input ready);
  modport sink   (input valid, input adc_sample, input elapsed_time, output ready);
endinterface

interface aldb_out_if;
  logic                       valid;
  logic                       ready;
  logic [aldb_pkg::BTN_W-1:0] pressed_button;

  modport source (output valid, output pressed_button, input ready);
  modport sink   (input valid, input pressed_button, output ready);
endinterface
`default_nettype wire

// File: rtl/adc_ladder_button_debounce_top.sv
// Ladder button debounce top: one request per cycle unless a waiting result stalls the input, state updated on accept.
// Latency: a press result is valid the cycle after its sample is accepted.
// Throughput: one sample per cycle; a result waiting in the output register
// stalls the input only in cycles where out ready is low.
// Reset (sync, active low): limits to 155/310/465/992, debounce 80, state cleared.
// Depends on aldb_pkg, aldb_if, aldb_step and the assertion macro header.
`default_nettype none
`include "adc_ladder_button_debounce_top_macros.svh"
module adc_ladder_button_debounce_top #(
  parameter int SAMPLE_WIDTH = aldb_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  aldb_in_if.sink                             in_ch,
  aldb_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [aldb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [aldb_pkg::REG_W-1:0]     cfg_data
);
  aldb_pkg::cfg_t   cfg_r;
  aldb_pkg::state_t state_r;
  aldb_pkg::step_t  step;
  logic             out_valid_r;
  logic [aldb_pkg::BTN_W-1:0] out_btn_r;
  logic             in_fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.pressed_button = out_btn_r;

  aldb_step #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_step (
    .adc_sample   (in_ch.adc_sample),
    .elapsed_time (in_ch.elapsed_time),
    .cfg          (cfg_r),
    .cur          (state_r),
    .step         (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.up_limit      <= aldb_pkg::UP_LIMIT_RST;
      cfg_r.right_limit   <= aldb_pkg::RIGHT_LIMIT_RST;
      cfg_r.down_limit    <= aldb_pkg::DOWN_LIMIT_RST;
      cfg_r.left_limit    <= aldb_pkg::LEFT_LIMIT_RST;
      cfg_r.debounce_time <= aldb_pkg::DEBOUNCE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aldb_pkg::REG_UP_LIMIT:    cfg_r.up_limit      <= cfg_data;
        aldb_pkg::REG_RIGHT_LIMIT: cfg_r.right_limit   <= cfg_data;
        aldb_pkg::REG_DOWN_LIMIT:  cfg_r.down_limit    <= cfg_data;
        aldb_pkg::REG_LEFT_LIMIT:  cfg_r.left_limit    <= cfg_data;
        aldb_pkg::REG_DEBOUNCE:    cfg_r.debounce_time <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.candidate_button <= aldb_pkg::BTN_NONE;
      state_r.stable_button    <= aldb_pkg::BTN_NONE;
      state_r.held_time        <= '0;
    end else if (in_fire) begin
      state_r <= step.state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && step.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && step.emit) begin
      out_btn_r <= step.pressed_button;
    end
  end

  `ALDB_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid_r, "output valid after reset")
  `ALDB_ASSERT(a_btn_code,
               out_valid_r |-> (out_btn_r != aldb_pkg::BTN_NONE &&
                                out_btn_r <= aldb_pkg::BTN_LEFT),
               "bad button code")
  `ALDB_ASSERT(a_emit_matches_stable,
               (in_fire && step.emit) |=>
                 (out_valid_r && out_btn_r == state_r.stable_button),
               "result differs from stable button")
  `ALDB_ASSERT(a_state_holds_idle, !in_fire |=> $stable(state_r), "state moved without request")
endmodule
`default_nettype wire

// File: rtl/aldb_step.sv
// Ladder decode and debounce next-state logic for one request.
// Depends on aldb_pkg.
`default_nettype none
module aldb_step #(
  parameter int SAMPLE_WIDTH = aldb_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic [SAMPLE_WIDTH-1:0]    adc_sample,
  input  wire logic [aldb_pkg::REG_W-1:0] elapsed_time,
  input  wire aldb_pkg::cfg_t             cfg,
  input  wire aldb_pkg::state_t           cur,
  output aldb_pkg::step_t                 step
);
  localparam int CMP_W = (SAMPLE_WIDTH > aldb_pkg::REG_W) ? SAMPLE_WIDTH : aldb_pkg::REG_W;
  localparam int HW    = aldb_pkg::HELD_W;

  logic [CMP_W-1:0]          level;
  logic [aldb_pkg::BTN_W-1:0] seen;
  logic [HW:0]               sum;
  logic [HW-1:0]             held_add;
  logic [HW-1:0]             deb;
  logic [HW-1:0]             held_n;
  logic                      reached;

  assign level = CMP_W'(adc_sample);
  assign deb   = HW'(cfg.debounce_time);

  always_comb begin
    priority if (level <= CMP_W'(cfg.up_limit)) begin
      seen = aldb_pkg::BTN_UP;
    end else if (level <= CMP_W'(cfg.right_limit)) begin
      seen = aldb_pkg::BTN_RIGHT;
    end else if (level <= CMP_W'(cfg.down_limit)) begin
      seen = aldb_pkg::BTN_DOWN;
    end else if (level <= CMP_W'(cfg.left_limit)) begin
      seen = aldb_pkg::BTN_LEFT;
    end else begin
      seen = aldb_pkg::BTN_NONE;
    end
  end

  assign sum      = (HW+1)'(cur.held_time) + (HW+1)'(elapsed_time);
  assign held_add = sum[HW] ? {HW{1'b1}} : sum[HW-1:0];
  assign held_n   = (cur.held_time < deb) ? held_add : cur.held_time;
  assign reached  = (held_n >= deb);

  always_comb begin
    step                = '0;
    step.state          = cur;
    step.pressed_button = cur.candidate_button;
    if (seen != cur.candidate_button) begin
      step.state.candidate_button = seen;
      step.state.held_time        = '0;
    end else begin
      step.state.held_time = held_n;
      if (reached && (cur.stable_button != cur.candidate_button)) begin
        step.state.stable_button = cur.candidate_button;
        step.emit = (cur.candidate_button != aldb_pkg::BTN_NONE);
      end
    end
  end
endmodule
`default_nettype wire

// File: test/tb_adc_ladder_button_debounce_top.sv
// Testbench for adc_ladder_button_debounce_top: random and directed ladder samples,
// with a scoreboard that tracks candidate/stable buttons and held time per accepted request.
// Depends on aldb_pkg, aldb_if and the RTL of the top level.
module tb_adc_ladder_button_debounce_top;
  timeunit 1ns;
  timeprecision 1ps;
  import aldb_pkg::*;

  localparam int SW          = SAMPLE_WIDTH_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_STALL  = 300;
  localparam int CHUNK_ITEMS = 165;
  localparam int NUM_CHUNKS  = 12;
  localparam int REG_MAX     = 2**REG_W - 1;
  localparam logic [HELD_W-1:0] HELD_MAX = '1;
  localparam logic [CFG_IDX_W-1:0] REG_IDX_LAST = '1;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data  = '0;

  aldb_in_if #(.SAMPLE_WIDTH(SW)) in_ch();
  aldb_out_if                     out_ch();

  adc_ladder_button_debounce_top #(.SAMPLE_WIDTH(SW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  class press_scoreboard;
    cfg_t             regs;
    state_t           st;
    logic [BTN_W-1:0] pending_presses[$];
    int               errors;

    function new();
      regs.up_limit      = UP_LIMIT_RST;
      regs.right_limit   = RIGHT_LIMIT_RST;
      regs.down_limit    = DOWN_LIMIT_RST;
      regs.left_limit    = LEFT_LIMIT_RST;
      regs.debounce_time = DEBOUNCE_RST;
      st     = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
      case (idx)
        REG_UP_LIMIT:    regs.up_limit = value;
        REG_RIGHT_LIMIT: regs.right_limit = value;
        REG_DOWN_LIMIT:  regs.down_limit = value;
        REG_LEFT_LIMIT:  regs.left_limit = value;
        REG_DEBOUNCE:    regs.debounce_time = value;
        default: ;
      endcase
    endfunction

    function logic [BTN_W-1:0] ladder_band(logic [SW-1:0] level);
      if (level <= regs.up_limit) return BTN_UP;
      if (level <= regs.right_limit) return BTN_RIGHT;
      if (level <= regs.down_limit) return BTN_DOWN;
      if (level <= regs.left_limit) return BTN_LEFT;
      return BTN_NONE;
    endfunction

    function void note_sample(logic [SW-1:0] level, logic [REG_W-1:0] elapsed);
      logic [BTN_W-1:0] seen;
      logic [HELD_W:0]  sum;
      seen = ladder_band(level);
      if (seen != st.candidate_button) begin
        st.candidate_button = seen;
        st.held_time = '0;
        return;
      end
      if (st.held_time < regs.debounce_time) begin
        sum = st.held_time + elapsed;
        st.held_time = (sum > HELD_MAX) ? HELD_MAX : sum[HELD_W-1:0];
        if (st.held_time < regs.debounce_time) return;
      end
      if (st.stable_button == st.candidate_button) return;
      st.stable_button = st.candidate_button;
      if (st.stable_button != BTN_NONE) pending_presses.push_back(st.stable_button);
    endfunction

    function void check_press(logic [BTN_W-1:0] got);
      logic [BTN_W-1:0] want;
      if (pending_presses.size() == 0) begin
        $display("%0t: pressed_button expected none actual %0d", $time, got);
        errors++;
        return;
      end
      want = pending_presses.pop_front();
      if (got !== want) begin
        $display("%0t: pressed_button expected %0d actual %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return pending_presses.size();
    endfunction
  endclass

  press_scoreboard sb = new();
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int stall_left   = 0;
  int quiet_cycles = 0;
  int items_sent   = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.adc_sample   = '0;
    in_ch.elapsed_time = '0;
    out_ch.ready       = 1'b0;
  end

  // receiver: random back-pressure, or a long hold-off on request
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_press(out_ch.pressed_button);
      if (in_ch.valid && in_ch.ready) sb.note_sample(in_ch.adc_sample, in_ch.elapsed_time);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no request accepted for %0d cycles", $time, QUIET_LIMIT);
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  task automatic push_sample(input logic [SW-1:0] level, input logic [REG_W-1:0] elapsed);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid        <= 1'b0;
      in_ch.adc_sample   <= $urandom;
      in_ch.elapsed_time <= $urandom;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.adc_sample   <= level;
    in_ch.elapsed_time <= elapsed;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.write_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic program_regs(input int up, input int right, input int down, input int left,
                              input int deb);
    write_reg(REG_UP_LIMIT, up);
    write_reg(REG_RIGHT_LIMIT, right);
    write_reg(REG_DOWN_LIMIT, down);
    write_reg(REG_LEFT_LIMIT, left);
    write_reg(REG_DEBOUNCE, deb);
    // unmapped index, must be ignored
    write_reg($urandom_range(REG_IDX_LAST, REG_DEBOUNCE + 1), $urandom);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // random level inside the band of btn; any level when that band is empty
  function automatic logic [SW-1:0] level_for(logic [BTN_W-1:0] btn);
    int lims[4];
    int lo;
    int hi;
    lims[0] = sb.regs.up_limit;
    lims[1] = sb.regs.right_limit;
    lims[2] = sb.regs.down_limit;
    lims[3] = sb.regs.left_limit;
    lo = 0;
    hi = (btn == BTN_NONE) ? REG_MAX : lims[btn - 1];
    for (int i = 0; i < 4; i++) begin
      if ((btn == BTN_NONE || i < btn - 1) && lims[i] + 1 > lo) lo = lims[i] + 1;
    end
    if (lo > hi) return $urandom;
    return $urandom_range(hi, lo);
  endfunction

  function automatic logic [REG_W-1:0] pick_elapsed();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(sb.regs.debounce_time, 0);
      2: return '0;
      default: return $urandom_range(40, 1);
    endcase
  endfunction

  task automatic send_press_run();
    logic [BTN_W-1:0] btn;
    int len;
    btn = $urandom_range(BTN_LEFT, BTN_NONE);
    len = $urandom_range(8, 1);
    repeat (len) begin
      if ($urandom_range(19) == 0) push_sample($urandom, pick_elapsed());
      else push_sample(level_for(btn), pick_elapsed());
      items_sent++;
    end
  endtask

  task automatic setup_chunk(input int k);
    int a;
    int b;
    int c;
    int d;
    a = $urandom_range(REG_MAX, 0);
    b = $urandom_range(REG_MAX, a);
    c = $urandom_range(REG_MAX, b);
    d = $urandom_range(REG_MAX, c);
    case (k % 6)
      0: program_regs(UP_LIMIT_RST, RIGHT_LIMIT_RST, DOWN_LIMIT_RST, LEFT_LIMIT_RST, DEBOUNCE_RST);
      1: program_regs(a, b, c, d, $urandom_range(200, 0));
      2: program_regs(0, 0, 0, 0, REG_MAX);
      3: program_regs(REG_MAX, REG_MAX, REG_MAX, REG_MAX, 0);
      4: program_regs($urandom_range(REG_MAX), $urandom_range(REG_MAX),
                      $urandom_range(REG_MAX), $urandom_range(REG_MAX), $urandom_range(REG_MAX));
      default: program_regs(a, b, c, d, $urandom_range(REG_MAX, 0));
    endcase
  endtask

  task automatic run_chunk(input int k);
    bit midpoint_done;
    midpoint_done = 0;
    items_sent = 0;
    while (items_sent < CHUNK_ITEMS) begin
      if (!midpoint_done && items_sent >= CHUNK_ITEMS / 2) begin
        midpoint_done = 1;
        if (k == 1 || k == 9) stall_left = LONG_STALL;
        if (k == 5) drain();
      end
      if ($urandom_range(9) < 7) begin
        send_press_run();
      end else begin
        push_sample($urandom, $urandom);
        items_sent++;
      end
    end
  endtask

  initial begin
    in_idle_pct  = 36;
    out_idle_pct = 75;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset limits: band edges, extreme elapsed times, release
    push_sample(0, REG_MAX);
    push_sample(0, REG_MAX);
    push_sample(0, 0);
    push_sample(0, 0);
    push_sample(REG_MAX, REG_MAX);
    push_sample(REG_MAX, REG_MAX);
    push_sample(155, REG_MAX);
    push_sample(155, REG_MAX);
    push_sample(156, 40);
    push_sample(310, 40);
    push_sample(310, 50);
    push_sample(311, 0);
    push_sample(465, 79);
    push_sample(465, 1);
    push_sample(466, REG_MAX);
    push_sample(992, REG_MAX);
    push_sample(993, 5);
    push_sample(REG_MAX, 100);
    drain();

    // limits out of order (right and left bands empty), zero debounce
    program_regs(600, 300, 800, 700, 0);
    push_sample(650, 0);
    push_sample(650, 0);
    push_sample(250, 0);
    push_sample(250, 0);
    push_sample(750, 0);
    push_sample(900, 0);
    push_sample(900, 0);
    drain();

    for (int k = 0; k < NUM_CHUNKS; k++) begin
      if (k < 4) begin
        in_idle_pct  = 36;
        out_idle_pct = 75;
      end else if (k < 8) begin
        in_idle_pct  = 75;
        out_idle_pct = 36;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      setup_chunk(k);
      run_chunk(k);
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/aldb_pkg.sv
rtl/aldb_if.sv
rtl/aldb_step.sv
rtl/adc_ladder_button_debounce_top.sv
test/tb_adc_ladder_button_debounce_top.sv
